FILE: hw/rtl/woc_pkg.sv
// Shared constants, types and helper functions for the weighted online covariance block.
package woc_pkg;

	localparam int SIZE = 16;
	localparam int IW = $clog2(SIZE);
	localparam int CW = $clog2(SIZE + 1);
	localparam int AW = $clog2(SIZE * SIZE);

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	localparam logic signed [63:0] COV_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] COV_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic signed [47:0] mean;
		logic signed [47:0] dev;
	} cell_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_PAD,
		ST_MEAN_GO,
		ST_MEAN_MUL,
		ST_MEAN_DIV,
		ST_F_GO,
		ST_F_MUL,
		ST_F_DIV,
		ST_COV_GO,
		ST_COV_MUL1,
		ST_COV_MUL2,
		ST_COV_WR,
		ST_COV_ROT
	} state_t;

	function automatic logic signed [47:0] clamp48(input logic signed [48:0] v);
		logic signed [47:0] r;
		if (v[48] != v[47]) begin
			r = v[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

	function automatic logic [47:0] mag48(input logic signed [47:0] d);
		logic [47:0] r;
		r = d[47] ? 48'(-d) : 48'(d);
		return r;
	endfunction

endpackage

FILE: hw/rtl/woc_cell.sv
// One cell of the rotating chain: holds a mean entry and its deviation.
module woc_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  logic          shift,
	input  woc_pkg::cell_t nbr,
	output woc_pkg::cell_t q
);
	import woc_pkg::*;

	logic signed [47:0] mean_q;
	logic signed [47:0] dev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= '0;
		end else if (clr) begin
			mean_q <= '0;
		end else if (shift) begin
			mean_q <= nbr.mean;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			dev_q <= nbr.dev;
		end
	end

	assign q.mean = mean_q;
	assign q.dev  = dev_q;

endmodule

FILE: hw/rtl/woc_mul.sv
// Multi-cycle 96 x 64 unsigned multiplier built on one 32 x 32 product per cycle.
module woc_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [95:0]  a,
	input  logic [63:0]  b,
	output logic [159:0] prod,
	output logic         done,
	output logic         busy
);
	logic [95:0]  a_q;
	logic [63:0]  b_q;
	logic [2:0]   cnt_q;
	logic         run_q;
	logic [63:0]  prod_s1;
	logic [1:0]   sh_s1;
	logic         v_s1;
	logic         last_s1;
	logic [159:0] acc_q;
	logic         done_q;
	logic [1:0]   ia;
	logic         ib;
	logic [31:0]  la;
	logic [31:0]  lb;
	logic [159:0] placed;

	assign ia = cnt_q[2:1];
	assign ib = cnt_q[0];

	always_comb begin
		case (ia)
			2'd0:    la = a_q[31:0];
			2'd1:    la = a_q[63:32];
			default: la = a_q[95:64];
		endcase
		lb = ib ? b_q[63:32] : b_q[31:0];
		case (sh_s1)
			2'd0:    placed = {96'b0, prod_s1};
			2'd1:    placed = {64'b0, prod_s1, 32'b0};
			2'd2:    placed = {32'b0, prod_s1, 64'b0};
			default: placed = {prod_s1, 96'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			v_s1    <= run_q;
			last_s1 <= run_q && (cnt_q == 3'd5);
			done_q  <= v_s1 && last_s1;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q <= a;
			b_q <= b;
		end
		prod_s1 <= la * lb;
		sh_s1   <= 2'(ia + {1'b0, ib});
		if (go) begin
			acc_q <= '0;
		end else if (v_s1) begin
			acc_q <= acc_q + placed;
		end
	end

	assign prod = acc_q;
	assign done = done_q;
	assign busy = run_q | v_s1;

endmodule

FILE: hw/rtl/woc_div.sv
// Restoring divider, one quotient bit per cycle; the quotient must fit in 48 bits.
module woc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [79:0] num,
	input  logic [31:0] den,
	output logic [47:0] quo,
	output logic        done,
	output logic        busy
);
	logic [31:0] rem_q;
	logic [47:0] low_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [32:0] t;
	logic [32:0] diff;
	logic        ge;

	assign t    = {rem_q, low_q[47]};
	assign diff = t - {1'b0, den_q};
	assign ge   = t >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd47) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The quotient bits shift in behind the dividend bits as they are consumed.
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= num[79:48];
			low_q <= num[47:0];
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? diff[31:0] : t[31:0];
			low_q <= {low_q[46:0], ge};
		end
	end

	assign quo  = low_q;
	assign done = done_q;
	assign busy = run_q;

endmodule

FILE: hw/rtl/weighted_online_covariance.sv
// Top level: weighted running mean and covariance with a rotating chain of cells.
// A sample element other than the last leaves busy low; a read item passes through ST_READ,
// then shows its result on done. A closing element keeps busy high while the chain pads and,
// with nonzero effective weight, through updates on the shared multiplier and serial divider.
// Results cannot be stalled: done is high for exactly one cycle per read.
// Asynchronous reset zeroes means, total weight and element count; covariances then read zero.
module weighted_online_covariance (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic signed [15:0] sample_value,
	input  logic [15:0]        sample_weight,
	input  logic               last_element,
	input  logic [3:0]         read_row,
	input  logic [3:0]         read_col,
	output logic               done,
	output logic signed [47:0] mean_value,
	output logic signed [63:0] cov_value,
	output logic [31:0]        weight_total
);
	import woc_pkg::*;

	state_t state_q, state_d;

	cell_t cells [SIZE];
	cell_t head;
	cell_t tail;
	logic  rot;
	logic  clr;

	logic [CW-1:0] idx_q;
	logic [CW-1:0] pad_q;
	logic [IW-1:0] cnt_q;
	logic [IW-1:0] row_q;
	logic [IW-1:0] col_q;
	logic [31:0]   total_q;
	logic [15:0]   weff_q;
	logic [31:0]   nw_q;
	logic [31:0]   f_q;
	logic signed [47:0] dj_q;
	logic               neg_q;
	logic signed [63:0] term_q;
	logic [AW-1:0]      addr_q;
	logic [IW-1:0]      ridx_q;
	logic               rrow_ok_q;
	logic               rcov_ok_q;
	logic               done_q;
	logic signed [47:0] mean_out_q;
	logic signed [63:0] cov_out_q;
	logic [31:0]        wt_out_q;

	logic               accept;
	logic               idx_room;
	logic [CW-1:0]      idx_next;
	logic [32:0]        wsum;
	logic [31:0]        nw_calc;
	logic signed [48:0] mean49;
	logic signed [48:0] xs49;
	logic signed [48:0] step49;
	logic signed [47:0] dev_elem;
	logic signed [47:0] dev_pad;
	logic signed [47:0] mean_new;
	logic signed [47:0] dj_use;
	logic [IW-1:0]      col_next;
	logic [AW-1:0]      cov_addr;
	logic [7:0]         rrow8;
	logic [7:0]         rcol8;
	logic [AW-1:0]      read_addr;

	logic               mul_go;
	logic [95:0]        mul_a;
	logic [63:0]        mul_b;
	logic [159:0]       mul_prod;
	logic               mul_done;
	logic               mul_busy;
	logic               div_go;
	logic [79:0]        div_num;
	logic [47:0]        div_quo;
	logic               div_done;
	logic               div_busy;

	logic [63:0]        mag64;
	logic               term_sat;
	logic signed [63:0] term_calc;

	logic signed [63:0] cov_mem [SIZE*SIZE];
	logic [SIZE*SIZE-1:0] cov_vld_q;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic signed [63:0] rd_data_q;
	logic               rd_vld_q;
	logic signed [63:0] cov_old;
	logic signed [63:0] cov_sum;
	logic signed [63:0] cov_new;
	logic               cov_we;

	// The chain shifts toward cell zero; the head feeds the arithmetic and the tail takes
	// the result, so one full rotation brings every entry back to its own cell.
	for (genvar i = 0; i < SIZE; i++) begin : g_cell
		cell_t nbr;
		if (i == SIZE - 1) begin : g_tail
			assign nbr = tail;
		end else begin : g_mid
			assign nbr = cells[i+1];
		end
		woc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.clr    (clr),
			.shift  (rot),
			.nbr    (nbr),
			.q      (cells[i])
		);
	end

	woc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (mul_prod),
		.done   (mul_done),
		.busy   (mul_busy)
	);

	woc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    (nw_q),
		.quo    (div_quo),
		.done   (div_done),
		.busy   (div_busy)
	);

	assign head   = cells[0];
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign idx_room = idx_q < CW'(SIZE);
	assign idx_next = idx_room ? CW'(idx_q + 1'b1) : idx_q;
	assign wsum     = {1'b0, total_q} + 33'(sample_weight);
	assign nw_calc  = wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];

	assign mean49   = {head.mean[47], head.mean};
	assign xs49     = {{17{sample_value[15]}}, sample_value, 16'b0};
	assign dev_elem = clamp48(xs49 - mean49);
	assign dev_pad  = clamp48(-mean49);
	assign step49   = head.dev[47] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
	assign mean_new = clamp48(mean49 + step49);
	assign dj_use   = (cnt_q == '0) ? head.dev : dj_q;

	assign col_next = (col_q == IW'(SIZE - 1)) ? '0 : IW'(col_q + 1'b1);
	assign cov_addr = AW'(AW'(row_q) * AW'(SIZE) + AW'(col_q));

	assign rrow8     = 8'(read_row);
	assign rcol8     = 8'(read_col);
	assign read_addr = AW'(AW'(rrow8[IW-1:0]) * AW'(SIZE) + AW'(rcol8[IW-1:0]));

	assign mag64     = mul_prod[95:32];
	assign term_sat  = (|mul_prod[159:96]) || mag64[63];
	assign term_calc = neg_q ? (term_sat ? COV_MIN : -$signed(mag64))
	                         : (term_sat ? COV_MAX : $signed(mag64));

	assign cov_old = rd_vld_q ? rd_data_q : '0;
	assign cov_sum = cov_old + term_q;
	assign cov_new = ((cov_old[63] == term_q[63]) && (cov_sum[63] != cov_old[63]))
	                 ? (cov_old[63] ? COV_MIN : COV_MAX) : cov_sum;
	assign cov_we  = (state_q == ST_COV_WR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rot     = 1'b0;
		tail    = head;
		clr     = 1'b0;
		mul_go  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		div_go  = 1'b0;
		div_num = '0;
		rd_en   = 1'b0;
		rd_addr = cov_addr;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (kind)
						KIND_SAMPLE: begin
							if (idx_room) begin
								rot       = 1'b1;
								tail.mean = head.mean;
								tail.dev  = dev_elem;
							end
							if (last_element) begin
								state_d = ST_PAD;
							end
						end
						KIND_READ: begin
							rd_en   = 1'b1;
							rd_addr = read_addr;
							state_d = ST_READ;
						end
						KIND_CLEAR: begin
							clr = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			ST_PAD: begin
				// Missing elements count as zero samples, which also brings the chain home.
				if (pad_q < CW'(SIZE)) begin
					rot       = 1'b1;
					tail.mean = head.mean;
					tail.dev  = dev_pad;
				end else if (weff_q != '0) begin
					state_d = ST_MEAN_GO;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_MEAN_GO: begin
				mul_go  = 1'b1;
				mul_a   = 96'(mag48(head.dev));
				mul_b   = 64'(weff_q);
				state_d = ST_MEAN_MUL;
			end
			ST_MEAN_MUL: begin
				if (mul_done) begin
					div_go  = 1'b1;
					div_num = mul_prod[79:0];
					state_d = ST_MEAN_DIV;
				end
			end
			ST_MEAN_DIV: begin
				if (div_done) begin
					rot       = 1'b1;
					tail.mean = mean_new;
					tail.dev  = head.dev;
					state_d   = (cnt_q == IW'(SIZE - 1)) ? ST_F_GO : ST_MEAN_GO;
				end
			end
			ST_F_GO: begin
				mul_go  = 1'b1;
				mul_a   = 96'(weff_q);
				mul_b   = 64'(nw_q - 32'(weff_q));
				state_d = ST_F_MUL;
			end
			ST_F_MUL: begin
				if (mul_done) begin
					div_go  = 1'b1;
					div_num = {mul_prod[63:0], 16'b0};
					state_d = ST_F_DIV;
				end
			end
			ST_F_DIV: begin
				if (div_done) begin
					state_d = ST_COV_GO;
				end
			end
			ST_COV_GO: begin
				mul_go  = 1'b1;
				mul_a   = 96'(mag48(dj_use));
				mul_b   = 64'(mag48(head.dev));
				rd_en   = 1'b1;
				state_d = ST_COV_MUL1;
			end
			ST_COV_MUL1: begin
				if (mul_done) begin
					mul_go  = 1'b1;
					mul_a   = mul_prod[95:0];
					mul_b   = {32'b0, f_q};
					state_d = ST_COV_MUL2;
				end
			end
			ST_COV_MUL2: begin
				if (mul_done) begin
					state_d = ST_COV_WR;
				end
			end
			ST_COV_WR: begin
				rot     = 1'b1;
				state_d = (cnt_q == IW'(SIZE - 1)) ? ST_COV_ROT : ST_COV_GO;
			end
			ST_COV_ROT: begin
				// One extra step per row puts the next row's deviation at the head.
				rot     = 1'b1;
				state_d = (row_q == IW'(SIZE - 1)) ? ST_IDLE : ST_COV_GO;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			pad_q   <= '0;
			cnt_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
			total_q <= '0;
			weff_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_READ);
			case (state_q)
				ST_IDLE: begin
					if (accept && (kind == KIND_SAMPLE)) begin
						idx_q <= idx_next;
						if (last_element) begin
							idx_q   <= '0;
							pad_q   <= idx_next;
							cnt_q   <= '0;
							total_q <= nw_calc;
							weff_q  <= 16'(nw_calc - total_q);
						end
					end else if (accept && (kind == KIND_CLEAR)) begin
						idx_q   <= '0;
						total_q <= '0;
					end
				end
				ST_PAD: begin
					if (rot) begin
						pad_q <= CW'(pad_q + 1'b1);
					end
				end
				ST_MEAN_DIV: begin
					if (div_done) begin
						cnt_q <= (cnt_q == IW'(SIZE - 1)) ? '0 : IW'(cnt_q + 1'b1);
					end
				end
				ST_F_DIV: begin
					row_q <= '0;
					col_q <= '0;
					cnt_q <= '0;
				end
				ST_COV_WR: begin
					col_q <= col_next;
					cnt_q <= (cnt_q == IW'(SIZE - 1)) ? '0 : IW'(cnt_q + 1'b1);
				end
				ST_COV_ROT: begin
					col_q <= col_next;
					row_q <= (row_q == IW'(SIZE - 1)) ? '0 : IW'(row_q + 1'b1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && kind == KIND_SAMPLE && last_element) begin
			nw_q <= nw_calc;
		end
		// Mid-vector the chain is turned by the element count, so the entry sits that far back.
		if (state_q == ST_IDLE && accept) begin
			ridx_q    <= IW'(rrow8[IW-1:0] - idx_q[IW-1:0]);
			rrow_ok_q <= rrow8 < 8'(SIZE);
			rcov_ok_q <= (rrow8 < 8'(SIZE)) && (rcol8 < 8'(SIZE));
		end
		if (state_q == ST_F_DIV && div_done) begin
			f_q <= div_quo[31:0];
		end
		if (state_q == ST_COV_GO) begin
			dj_q   <= dj_use;
			neg_q  <= dj_use[47] ^ head.dev[47];
			addr_q <= cov_addr;
		end
		if (state_q == ST_COV_MUL2 && mul_done) begin
			term_q <= term_calc;
		end
		if (state_q == ST_READ) begin
			mean_out_q <= rrow_ok_q ? cells[ridx_q].mean : '0;
			cov_out_q  <= rcov_ok_q ? cov_old : '0;
			wt_out_q   <= total_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= cov_mem[rd_addr];
		end
		if (cov_we) begin
			cov_mem[addr_q] <= cov_new;
		end
	end

	// An entry never written since reset or clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cov_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= cov_vld_q[rd_addr];
			end
			if (clr) begin
				cov_vld_q <= '0;
			end else if (cov_we) begin
				cov_vld_q[addr_q] <= 1'b1;
			end
		end
	end

	assign done         = done_q;
	assign mean_value   = mean_out_q;
	assign cov_value    = cov_out_q;
	assign weight_total = wt_out_q;

	a_done_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_READ))
		else $error("result beat without a read");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= CW'(SIZE))
		else $error("element count beyond vector size");

	a_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(mul_busy || div_busy))
		else $error("arithmetic unit running while idle");

	a_write_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COV_WR) |-> $past(state_q == ST_COV_MUL2))
		else $error("covariance write without a finished term");

endmodule
